/* hdl/wwg_pkg.sv */
package wwg_pkg;

  localparam int MAX_WIDTH_DEF  = 64;
  localparam int MAX_HEIGHT_DEF = 64;

  localparam int CFG_W = 7;
  localparam int CNT_W = 13;
  localparam int GEN_W = 32;

  localparam logic [CFG_W-1:0] GRID_RESET = 7'd64;
  localparam logic [CNT_W-1:0] COUNT_MAX  = 13'd8191;

  localparam logic [1:0] CELL_EMPTY = 2'd0;
  localparam logic [1:0] CELL_COND  = 2'd1;
  localparam logic [1:0] CELL_HEAD  = 2'd2;
  localparam logic [1:0] CELL_TAIL  = 2'd3;

  localparam logic [1:0] REQ_WRITE = 2'd0;
  localparam logic [1:0] REQ_READ  = 2'd1;
  localparam logic [1:0] REQ_STEP  = 2'd2;

  localparam logic REG_WIDTH_IDX  = 1'b0;
  localparam logic REG_HEIGHT_IDX = 1'b1;

  typedef struct packed {
    logic shift;
    logic left;
    logic right;
    logic up;
    logic down;
  } win_ctrl_t;

endpackage

/* hdl/wwg_ram.sv */
module wwg_ram #(
  parameter int WIDTH = 2,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* hdl/wwg_window.sv */
module wwg_window #(
  parameter int MAX_WIDTH = wwg_pkg::MAX_WIDTH_DEF
) (
  input  logic              clk,
  input  wwg_pkg::win_ctrl_t ctrl,
  input  logic [1:0]        cell_in,
  output logic [1:0]        center,
  output logic [1:0]        next
);

  localparam int CHAIN = 2 * MAX_WIDTH + 3;

  logic [1:0] sr [CHAIN];
  logic [3:0] heads;

  always_ff @(posedge clk) begin
    if (ctrl.shift) begin
      sr[0] <= cell_in;
      for (int i = 1; i < CHAIN; i++) begin
        sr[i] <= sr[i-1];
      end
    end
  end

  assign center = sr[MAX_WIDTH+1];

  always_comb begin
    heads = '0;
    if (ctrl.down && ctrl.right && sr[0] == wwg_pkg::CELL_HEAD) heads = heads + 4'd1;
    if (ctrl.down && sr[1] == wwg_pkg::CELL_HEAD) heads = heads + 4'd1;
    if (ctrl.down && ctrl.left && sr[2] == wwg_pkg::CELL_HEAD) heads = heads + 4'd1;
    if (ctrl.right && sr[MAX_WIDTH] == wwg_pkg::CELL_HEAD) heads = heads + 4'd1;
    if (ctrl.left && sr[MAX_WIDTH+2] == wwg_pkg::CELL_HEAD) heads = heads + 4'd1;
    if (ctrl.up && ctrl.right && sr[2*MAX_WIDTH] == wwg_pkg::CELL_HEAD) heads = heads + 4'd1;
    if (ctrl.up && sr[2*MAX_WIDTH+1] == wwg_pkg::CELL_HEAD) heads = heads + 4'd1;
    if (ctrl.up && ctrl.left && sr[2*MAX_WIDTH+2] == wwg_pkg::CELL_HEAD) heads = heads + 4'd1;
  end

  always_comb begin
    unique case (center)
      wwg_pkg::CELL_HEAD: next = wwg_pkg::CELL_TAIL;
      wwg_pkg::CELL_TAIL: next = wwg_pkg::CELL_COND;
      wwg_pkg::CELL_COND: next = (heads == 4'd1 || heads == 4'd2) ?
                                 wwg_pkg::CELL_HEAD : wwg_pkg::CELL_COND;
      default:            next = wwg_pkg::CELL_EMPTY;
    endcase
  end

endmodule

/* hdl/wireworld_grid_step_core.sv */
// channel   direction  payload                                             handshake
// request   in         req_type, cell_x, cell_y, cell_value                req_valid/req_ready
// response  out        read_value, generation_count, head_total, tail_total rsp_valid/rsp_ready
// config    in/out     APB, width at 0x0, height at 0x4                    psel/penable/pready
//
// a response is ready after one raster sweep over the cell RAM, one cell per cycle
// through a line window; the next request is taken once the response has moved to
// the output register
// after reset a clearing pass writes every cell empty, with req_ready low
// one request in flight; a finished response waits in the output register
module wireworld_grid_step_core #(
  parameter int MAX_WIDTH  = wwg_pkg::MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = wwg_pkg::MAX_HEIGHT_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        req_valid,
  output logic        req_ready,
  input  logic [1:0]  req_type,
  input  logic [5:0]  cell_x,
  input  logic [5:0]  cell_y,
  input  logic [1:0]  cell_value,
  output logic        rsp_valid,
  input  logic        rsp_ready,
  output logic [1:0]  read_value,
  output logic [31:0] generation_count,
  output logic [12:0] head_total,
  output logic [12:0] tail_total,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int N  = MAX_WIDTH * MAX_HEIGHT;
  localparam int AW = $clog2(N);
  localparam int CW = $clog2(N + MAX_WIDTH + 3);
  localparam int XW = $clog2(MAX_WIDTH);
  localparam int YW = $clog2(MAX_HEIGHT);
  localparam int EW = $clog2(MAX_WIDTH + 1);
  localparam int HW = $clog2(MAX_HEIGHT + 1);

  localparam logic [CW-1:0] CNT_N      = CW'(N);
  localparam logic [CW-1:0] CLEAR_LAST = CW'(N - 1);
  localparam logic [CW-1:0] PROC_FIRST = CW'(MAX_WIDTH + 3);
  localparam logic [CW-1:0] SWEEP_LAST = CW'(N + MAX_WIDTH + 2);
  localparam logic [XW-1:0] X_LAST     = XW'(MAX_WIDTH - 1);

  typedef enum logic [5:0] {
    ST_CLEAR  = 6'b000001,
    ST_IDLE   = 6'b000010,
    ST_ACCESS = 6'b000100,
    ST_FETCH  = 6'b001000,
    ST_SWEEP  = 6'b010000,
    ST_DONE   = 6'b100000
  } state_t;

  state_t state;
  state_t state_next;

  logic [6:0]    cfg_w;
  logic [6:0]    cfg_h;
  logic [EW-1:0] eff_w;
  logic [HW-1:0] eff_h;

  logic [CW-1:0] cnt;
  logic [1:0]    op;
  logic [AW-1:0] acc_addr;
  logic          acc_inside;
  logic [1:0]    acc_value;
  logic [1:0]    rd_val;
  logic [31:0]   gen;
  logic [12:0]   heads;
  logic [12:0]   tails;
  logic [XW-1:0] cx;
  logic [YW-1:0] cy;
  logic [AW-1:0] ca;
  logic          live;

  logic          ram_we;
  logic [AW-1:0] ram_waddr;
  logic [1:0]    ram_wdata;
  logic [AW-1:0] ram_raddr;
  logic [1:0]    ram_rdata;

  wwg_pkg::win_ctrl_t win;
  logic [1:0] center;
  logic [1:0] nxt;
  logic [1:0] newv;
  logic       proc;
  logic       inside_c;

  // register clamp
  always_comb begin
    if (cfg_w == '0) begin
      eff_w = EW'(1);
    end else if (32'(cfg_w) > MAX_WIDTH) begin
      eff_w = EW'(MAX_WIDTH);
    end else begin
      eff_w = EW'(cfg_w);
    end
    if (cfg_h == '0) begin
      eff_h = HW'(1);
    end else if (32'(cfg_h) > MAX_HEIGHT) begin
      eff_h = HW'(MAX_HEIGHT);
    end else begin
      eff_h = HW'(cfg_h);
    end
  end

  assign pready = 1'b1;
  assign prdata = (paddr[2] == wwg_pkg::REG_HEIGHT_IDX) ? 32'(cfg_h) : 32'(cfg_w);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_w <= wwg_pkg::GRID_RESET;
      cfg_h <= wwg_pkg::GRID_RESET;
    end else if (psel && penable && pwrite && pready) begin
      if (paddr[2] == wwg_pkg::REG_WIDTH_IDX) begin
        cfg_w <= pwdata[6:0];
      end else begin
        cfg_h <= pwdata[6:0];
      end
    end
  end

  assign req_ready = (state == ST_IDLE);
  assign proc      = (state == ST_SWEEP) && (cnt >= PROC_FIRST);
  assign inside_c  = (32'(cx) < 32'(eff_w)) && (32'(cy) < 32'(eff_h));

  assign win.shift = (state == ST_SWEEP);
  assign win.left  = (cx != '0);
  assign win.right = (32'(cx) + 32'd1 < 32'(eff_w));
  assign win.up    = (cy != '0);
  assign win.down  = (32'(cy) + 32'd1 < 32'(eff_h));

  wwg_window #(
    .MAX_WIDTH(MAX_WIDTH)
  ) u_window (
    .clk    (clk),
    .ctrl   (win),
    .cell_in(live ? ram_rdata : wwg_pkg::CELL_EMPTY),
    .center (center),
    .next   (nxt)
  );

  assign newv = (op == wwg_pkg::REQ_STEP) ? nxt : center;

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = acc_addr;
    ram_wdata = acc_value;
    ram_raddr = acc_addr;
    unique case (state)
      ST_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = cnt[AW-1:0];
        ram_wdata = wwg_pkg::CELL_EMPTY;
      end
      ST_ACCESS: begin
        ram_we = (op == wwg_pkg::REQ_WRITE) && acc_inside;
      end
      ST_SWEEP: begin
        ram_we    = proc && inside_c && (op == wwg_pkg::REQ_STEP);
        ram_waddr = ca;
        ram_wdata = nxt;
        ram_raddr = (cnt < CNT_N) ? cnt[AW-1:0] : '0;
      end
      default: begin
      end
    endcase
  end

  wwg_ram #(
    .WIDTH(2),
    .DEPTH(N)
  ) u_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  always_comb begin
    state_next = state;
    unique case (state)
      ST_CLEAR:  if (cnt == CLEAR_LAST) state_next = ST_IDLE;
      ST_IDLE:   if (req_valid) state_next = ST_ACCESS;
      ST_ACCESS: state_next = ST_FETCH;
      ST_FETCH:  state_next = ST_SWEEP;
      ST_SWEEP:  if (cnt == SWEEP_LAST) state_next = ST_DONE;
      ST_DONE:   if (!rsp_valid || rsp_ready) state_next = ST_IDLE;
      default:   state_next = ST_CLEAR;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_CLEAR;
      cnt       <= '0;
      gen       <= '0;
      heads     <= '0;
      tails     <= '0;
      live      <= 1'b0;
      rsp_valid <= 1'b0;
    end else begin
      state <= state_next;
      live  <= (state == ST_SWEEP) && (cnt < CNT_N);
      if (rsp_valid && rsp_ready && state != ST_DONE) begin
        rsp_valid <= 1'b0;
      end
      unique case (state)
        ST_CLEAR: begin
          cnt <= cnt + CW'(1);
        end
        ST_IDLE: begin
          if (req_valid) begin
            op         <= req_type;
            acc_value  <= cell_value;
            acc_addr   <= AW'(32'(cell_x) + 32'(cell_y) * MAX_WIDTH);
            acc_inside <= (32'(cell_x) < 32'(eff_w)) && (32'(cell_y) < 32'(eff_h));
          end
        end
        ST_ACCESS: begin
          rd_val <= wwg_pkg::CELL_EMPTY;
          if (op == wwg_pkg::REQ_STEP) begin
            gen <= gen + 32'd1;
          end
        end
        ST_FETCH: begin
          if (op == wwg_pkg::REQ_READ && acc_inside) begin
            rd_val <= ram_rdata;
          end
          cnt   <= '0;
          heads <= '0;
          tails <= '0;
          cx    <= '0;
          cy    <= '0;
          ca    <= '0;
        end
        ST_SWEEP: begin
          cnt <= cnt + CW'(1);
          if (proc) begin
            ca <= ca + AW'(1);
            if (cx == X_LAST) begin
              cx <= '0;
              cy <= cy + YW'(1);
            end else begin
              cx <= cx + XW'(1);
            end
            if (inside_c) begin
              if (newv == wwg_pkg::CELL_HEAD && heads != wwg_pkg::COUNT_MAX) begin
                heads <= heads + 13'd1;
              end
              if (newv == wwg_pkg::CELL_TAIL && tails != wwg_pkg::COUNT_MAX) begin
                tails <= tails + 13'd1;
              end
            end
          end
        end
        ST_DONE: begin
          if (!rsp_valid || rsp_ready) begin
            rsp_valid        <= 1'b1;
            read_value       <= rd_val;
            generation_count <= gen;
            head_total       <= heads;
            tail_total       <= tails;
          end
        end
        default: begin
        end
      endcase
    end
  end

endmodule
